// ----- rtl/rdw_pkg.sv -----
// rdw_pkg: shared constants, types and the control store of the radix digit writer.
// Depends on nothing; imported by radix_digit_writer_unit.
`default_nettype none

package rdw_pkg;

  localparam int VALUE_BITS         = 64;  // width of the value port
  localparam int RADIX_BITS         = 5;
  localparam int DIGIT_BITS         = 4;
  localparam int CHAR_BITS          = 7;
  localparam int DEFAULT_VALUE_WIDTH = 64;
  localparam int DEFAULT_MAX_DIGITS  = 64;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h37;  // 'A' - 10

  // sequencer step addresses
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_STORE,
    ST_EMIT_SETUP,
    ST_READ,
    ST_OUT,
    ST_DONE
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,        // never jump, fall through
    C_ALWAYS,
    C_NO_START,
    C_BIT_MORE,    // division bits remain
    C_DIGIT_MORE,  // quotient nonzero and room for another digit
    C_PTR_MORE     // digits remain to be sent
  } cond_t;

  typedef struct packed {
    logic  load;     // take value when a word is accepted
    logic  clr_rem;  // start a new division
    logic  div;      // one restoring shift-subtract step
    logic  store;    // write remainder, bump digit count
    logic  set_ptr;  // read pointer to most significant digit
    logic  rd;       // registered read of the digit store
    logic  emit;     // drive one result word
    cond_t cond;
    step_t target;
  } cw_t;

  // control store
  function automatic cw_t ucode(input step_t s);
    cw_t w;
    w = '{load: 1'b0, clr_rem: 1'b0, div: 1'b0, store: 1'b0, set_ptr: 1'b0,
          rd: 1'b0, emit: 1'b0, cond: C_NEXT, target: ST_IDLE};
    unique case (s)
      ST_IDLE: begin
        w.load = 1'b1; w.cond = C_NO_START; w.target = ST_IDLE;
      end
      ST_DIV_INIT: begin
        w.clr_rem = 1'b1;
      end
      ST_DIV_STEP: begin
        w.div = 1'b1; w.cond = C_BIT_MORE; w.target = ST_DIV_STEP;
      end
      ST_STORE: begin
        w.store = 1'b1; w.cond = C_DIGIT_MORE; w.target = ST_DIV_INIT;
      end
      ST_EMIT_SETUP: begin
        w.set_ptr = 1'b1;
      end
      ST_READ: begin
        w.rd = 1'b1;
      end
      ST_OUT: begin
        w.emit = 1'b1; w.cond = C_PTR_MORE; w.target = ST_READ;
      end
      ST_DONE: begin
        w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d);
    if (d < 4'd10) return CHAR_ZERO + CHAR_BITS'(d);
    else           return CHAR_ALPHA + CHAR_BITS'(d);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/radix_digit_writer_unit.sv -----
// radix_digit_writer_unit: unsigned integer to ASCII text in base 2..16.
// Depends on rdw_pkg (types, control store, glyph function).
`default_nettype none

// Usage
//   Input: drive value and raise start; the word is taken at a clock edge
//   with start high and busy low. busy stays high until the last digit has
//   been sent.
//   Output: one word per digit, most significant first, each on digit_char
//   for exactly one cycle while digit_valid is high. last_digit marks the
//   final (least significant) digit. The receiver cannot stall.
//   Config: radix_write loads radix_data into the radix register (reset 10);
//   0 and 1 act as 2, 17..31 act as 16. Write only while busy is low.
// Operation
//   A microcoded sequencer drives a bit-serial restoring divider. Each digit
//   comes from one division (one quotient bit per cycle); when all digits
//   are stored, each is read back from the digit store and sent.
//   At most MAX_DIGITS low-order digits are produced.
// Reset
//   Synchronous, active high: sequencer idle, radix back to 10, no strobe.

module radix_digit_writer_unit
  import rdw_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,  // 8..64
  parameter int MAX_DIGITS  = DEFAULT_MAX_DIGITS    // 8..64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] value,
  // result channel
  output logic                       digit_valid,
  output logic [CHAR_BITS-1:0]       digit_char,
  output logic                       last_digit,
  // configuration
  input  wire logic                  radix_write,
  input  wire logic [RADIX_BITS-1:0] radix_data
);

  localparam int AW = $clog2(MAX_DIGITS);      // digit store address
  localparam int CW = $clog2(MAX_DIGITS + 1);  // digit count
  localparam int BW = $clog2(VALUE_WIDTH);     // division bit counter

  // sequencer
  step_t upc;
  step_t upc_next;
  cw_t   cw;
  logic  take;

  // datapath
  logic [RADIX_BITS-1:0]  radix;
  logic [RADIX_BITS-1:0]  base;
  logic [VALUE_WIDTH-1:0] quot;      // remaining quotient
  logic [DIGIT_BITS-1:0]  rem;
  logic [BW-1:0]          bcnt;
  logic [CW-1:0]          n;         // digit count
  logic [AW-1:0]          ptr;
  logic [DIGIT_BITS-1:0]  rdata;
  logic [DIGIT_BITS-1:0]  digit_store [MAX_DIGITS];

  logic [RADIX_BITS-1:0]  trial;
  logic                   qbit;
  logic [DIGIT_BITS-1:0]  rem_next;

  assign busy = (upc != ST_IDLE);
  assign cw   = ucode(upc);

  // clamp the base into 2..16
  always_comb begin
    if (radix < RADIX_MIN)      base = RADIX_MIN;
    else if (radix > RADIX_MAX) base = RADIX_MAX;
    else                        base = radix;
  end

  // restoring division step: shift in next dividend bit, try to subtract
  assign trial    = {rem, quot[VALUE_WIDTH-1]};
  assign qbit     = (trial >= base);
  assign rem_next = qbit ? DIGIT_BITS'(trial - base) : trial[DIGIT_BITS-1:0];

  // jump condition and next step
  always_comb begin
    unique case (cw.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_START:   take = !start;
      C_BIT_MORE:   take = (bcnt != BW'(VALUE_WIDTH - 1));
      C_DIGIT_MORE: take = (quot != '0) && ((n + CW'(1)) < CW'(MAX_DIGITS));
      C_PTR_MORE:   take = (ptr != '0);
      default:      take = 1'b0;
    endcase
    upc_next = take ? cw.target : step_t'(3'(upc + 3'd1));
  end

  // sequencer, control registers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      upc         <= ST_IDLE;
      radix       <= RADIX_RESET;
      digit_valid <= 1'b0;
      n           <= '0;
      quot        <= '0;
    end else begin
      upc         <= upc_next;
      digit_valid <= cw.emit;
      if (radix_write) radix <= radix_data;
      if (cw.load && start) begin
        quot <= value[VALUE_WIDTH-1:0];
        n    <= '0;
      end
      if (cw.div)   quot <= {quot[VALUE_WIDTH-2:0], qbit};
      if (cw.store) n    <= n + CW'(1);
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (cw.clr_rem) begin
      rem  <= '0;
      bcnt <= '0;
    end
    if (cw.div) begin
      rem  <= rem_next;
      bcnt <= bcnt + BW'(1);
    end
    if (cw.set_ptr) ptr <= AW'(n - CW'(1));
    if (cw.emit) begin
      ptr        <= ptr - AW'(1);
      digit_char <= glyph(rdata);
      last_digit <= (ptr == '0);
    end
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cw.store) digit_store[n[AW-1:0]] <= rem;
    if (cw.rd)    rdata <= digit_store[ptr];
  end

  // checks
  a_strobe_in_run: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> busy)
    else $error("result strobe outside a conversion");

  a_last_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && last_digit) |-> (upc == ST_DONE))
    else $error("final digit not followed by end of run");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (upc == ST_DIV_INIT) && (n == '0))
    else $error("accepted word did not start a division");

  a_store_bounded: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

endmodule

`default_nettype wire
